/* hw/rtl/json_byte_lexer_unit_assert.svh */
// ----------------------------------------------------------------------------
// JSON byte lexer assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef JSON_BYTE_LEXER_UNIT_ASSERT_SVH
`define JSON_BYTE_LEXER_UNIT_ASSERT_SVH

// condition holding in the same cycle
`define JBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holding in the following cycle
`define JBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/jbl_pkg.sv */
// ----------------------------------------------------------------------------
// jbl_pkg
// Token types, token kind codes and character constants of the JSON lexer.
// ----------------------------------------------------------------------------
package jbl_pkg;

    localparam int FIELD_W   = 16;
    localparam int KIND_W    = 4;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    localparam int TOKQ_DEPTH = 4;
    localparam int TOKQ_AW    = 2;

    localparam logic [KIND_W-1:0] K_LBRACE = 4'd0;
    localparam logic [KIND_W-1:0] K_LBRACK = 4'd1;
    localparam logic [KIND_W-1:0] K_RBRACE = 4'd2;
    localparam logic [KIND_W-1:0] K_RBRACK = 4'd3;
    localparam logic [KIND_W-1:0] K_COLON  = 4'd4;
    localparam logic [KIND_W-1:0] K_COMMA  = 4'd5;
    localparam logic [KIND_W-1:0] K_NUMBER = 4'd6;
    localparam logic [KIND_W-1:0] K_STRING = 4'd7;
    localparam logic [KIND_W-1:0] K_TRUE   = 4'd8;
    localparam logic [KIND_W-1:0] K_FALSE  = 4'd9;
    localparam logic [KIND_W-1:0] K_NULL   = 4'd10;
    localparam logic [KIND_W-1:0] K_ERROR  = 4'd11;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic               last;
    } tok_t;

    // tokens produced by one byte, compacted: v1 implies v0
    typedef struct packed {
        logic v0;
        logic v1;
        tok_t t0;
        tok_t t1;
    } push_t;

    typedef struct packed {
        logic               room;
        logic [TOKQ_AW:0]   count;
    } tokq_stat_t;

    // literal letters: kind 0 true, 1 false, 2 null
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            2'd0: begin
                case (idx)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [KIND_W-1:0] lit_code(input logic [1:0] k);
        logic [KIND_W-1:0] code;
        unique case (k)
            2'd0:    code = K_TRUE;
            2'd1:    code = K_FALSE;
            default: code = K_NULL;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/jbl_core.sv */
// ----------------------------------------------------------------------------
// jbl_core
// Lexer mode machine: one byte per step, up to two tokens out per step.
// ----------------------------------------------------------------------------
module jbl_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      text_byte,
    input  logic            end_of_text,
    output jbl_pkg::push_t  push
);
    import jbl_pkg::*;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_STR     = 4'd1;
    localparam logic [3:0] M_ESC     = 4'd2;
    localparam logic [3:0] M_LIT     = 4'd3;
    localparam logic [3:0] M_MINUS   = 4'd4;
    localparam logic [3:0] M_ZERO    = 4'd5;
    localparam logic [3:0] M_INT     = 4'd6;
    localparam logic [3:0] M_DOT     = 4'd7;
    localparam logic [3:0] M_FRAC    = 4'd8;
    localparam logic [3:0] M_EXP     = 4'd9;
    localparam logic [3:0] M_EXPSIGN = 4'd10;
    localparam logic [3:0] M_EXPDIG  = 4'd11;
    localparam logic [3:0] M_ERR     = 4'd12;

    localparam int W1 = OFFSET_BITS + 1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    typedef logic [OFFSET_BITS-1:0] pos_t;

    logic [3:0] mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       begin_reg, begin_next;
    logic [2:0] idx_reg, idx_next;
    logic [1:0] lkind_reg, lkind_next;

    function automatic logic [FIELD_W-1:0] to_field(input pos_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] span(input pos_t p, input pos_t b, input logic inc);
        logic [W1-1:0] d;
        d = {1'b0, p} - {1'b0, b} + W1'(inc);
        if (d > {1'b0, POS_MAX}) begin
            d = {1'b0, POS_MAX};
        end
        return to_field(d[OFFSET_BITS-1:0]);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic accepting(input logic [3:0] m);
        return (m == M_ZERO) || (m == M_INT) || (m == M_FRAC) || (m == M_EXPDIG);
    endfunction

    function automatic logic [3:0] number_next(input logic [3:0] m, input logic [7:0] c);
        logic       d;
        logic       e;
        logic [3:0] nx;
        d = is_digit(c);
        e = (c == "e") || (c == "E");
        unique case (m)
            M_MINUS:   nx = (c == "0") ? M_ZERO : d ? M_INT : M_ERR;
            M_ZERO:    nx = (c == ".") ? M_DOT : e ? M_EXP : M_ERR;
            M_INT:     nx = d ? M_INT : (c == ".") ? M_DOT : e ? M_EXP : M_ERR;
            M_DOT:     nx = d ? M_FRAC : M_ERR;
            M_FRAC:    nx = d ? M_FRAC : e ? M_EXP : M_ERR;
            M_EXP:     nx = ((c == "+") || (c == "-")) ? M_EXPSIGN : d ? M_EXPDIG : M_ERR;
            M_EXPSIGN: nx = d ? M_EXPDIG : M_ERR;
            M_EXPDIG:  nx = d ? M_EXPDIG : M_ERR;
            default:   nx = M_ERR;
        endcase
        return nx;
    endfunction

    // byte classes
    logic              c_ws, c_punct, c_esc;
    logic [KIND_W-1:0] c_pkind;

    always_comb begin
        c_ws    = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
        c_punct = 1'b1;
        c_pkind = K_LBRACE;
        case (text_byte)
            "{":     c_pkind = K_LBRACE;
            "[":     c_pkind = K_LBRACK;
            "}":     c_pkind = K_RBRACE;
            "]":     c_pkind = K_RBRACK;
            ":":     c_pkind = K_COLON;
            ",":     c_pkind = K_COMMA;
            default: c_punct = 1'b0;
        endcase
        c_esc = (text_byte == CH_QUOTE) || (text_byte == CH_BSL) || (text_byte == "/") ||
                (text_byte == "b") || (text_byte == "f") || (text_byte == "n") ||
                (text_byte == "r") || (text_byte == "t") || (text_byte == "u");
    end

    // token start from idle
    logic              st_emit;
    logic [KIND_W-1:0] st_kind;
    logic [3:0]        st_mode;
    logic              st_lit;
    logic [1:0]        st_lkind;

    always_comb begin
        st_emit  = 1'b0;
        st_kind  = c_pkind;
        st_mode  = M_IDLE;
        st_lit   = 1'b0;
        st_lkind = 2'd0;
        if (c_ws) begin
            st_mode = M_IDLE;
        end else if (c_punct) begin
            st_emit = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
            st_mode = M_STR;
        end else if (text_byte == "-") begin
            st_mode = M_MINUS;
        end else if (text_byte == "0") begin
            st_mode = M_ZERO;
        end else if (is_digit(text_byte)) begin
            st_mode = M_INT;
        end else if ((text_byte == "t") || (text_byte == "f") || (text_byte == "n")) begin
            st_mode  = M_LIT;
            st_lit   = 1'b1;
            st_lkind = (text_byte == "t") ? 2'd0 : (text_byte == "f") ? 2'd1 : 2'd2;
        end else begin
            st_emit = 1'b1;
            st_kind = K_ERROR;
            st_mode = M_ERR;
        end
    end

    logic [1:0]  lk;
    logic [2:0]  idx_inc;
    logic        e0, e1, e2;
    tok_t        k0, k1, k2;
    logic [3:0]  mode_a;
    pos_t        begin_a;
    logic [2:0]  idx_a;
    logic [1:0]  lkind_a;

    always_comb begin
        lk      = (lkind_reg == 2'd3) ? 2'd2 : lkind_reg;
        idx_inc = idx_reg + 3'd1;
        mode_a  = mode_reg;
        begin_a = begin_reg;
        idx_a   = idx_reg;
        lkind_a = lkind_reg;
        e0 = 1'b0;
        e1 = 1'b0;
        e2 = 1'b0;
        k0 = '{kind: K_ERROR, offset: to_field(begin_reg),
               length: span(pos_reg, begin_reg, 1'b1), last: 1'b0};
        k1 = '{kind: st_kind, offset: to_field(pos_reg), length: 16'd1, last: 1'b0};
        k2 = '{kind: K_ERROR, offset: '0, length: '0, last: 1'b0};

        unique case (mode_reg) inside
            M_IDLE: begin
                begin_a = pos_reg;
                mode_a  = st_mode;
                if (st_lit) begin
                    lkind_a = st_lkind;
                    idx_a   = 3'd1;
                end
                e0 = st_emit;
                k0 = '{kind: st_kind, offset: to_field(pos_reg), length: 16'd1, last: 1'b0};
            end
            M_STR: begin
                if (text_byte == CH_BSL) begin
                    mode_a = M_ESC;
                end else if (text_byte == CH_QUOTE) begin
                    e0      = 1'b1;
                    k0.kind = K_STRING;
                    mode_a  = M_IDLE;
                end
            end
            M_ESC: begin
                if (c_esc) begin
                    mode_a = M_STR;
                end else begin
                    e0     = 1'b1;
                    mode_a = M_ERR;
                end
            end
            M_LIT: begin
                if ((idx_reg < lit_len(lk)) && (text_byte == lit_char(lk, idx_reg))) begin
                    idx_a = idx_inc;
                    if (idx_inc == lit_len(lk)) begin
                        e0      = 1'b1;
                        k0.kind = lit_code(lk);
                        mode_a  = M_IDLE;
                        idx_a   = 3'd0;
                    end
                end else begin
                    e0     = 1'b1;
                    mode_a = M_ERR;
                end
            end
            M_MINUS, M_ZERO, M_INT, M_DOT, M_FRAC, M_EXP, M_EXPSIGN, M_EXPDIG: begin
                if (accepting(mode_reg) && (c_ws || c_punct)) begin
                    e0       = 1'b1;
                    k0.kind  = K_NUMBER;
                    k0.length = span(pos_reg, begin_reg, 1'b0);
                    begin_a  = pos_reg;
                    mode_a   = st_mode;
                    e1       = st_emit;
                end else if (number_next(mode_reg, text_byte) == M_ERR) begin
                    e0     = 1'b1;
                    mode_a = M_ERR;
                end else begin
                    mode_a = number_next(mode_reg, text_byte);
                end
            end
            default: begin
                mode_a = mode_reg;
            end
        endcase

        if (end_of_text) begin
            k2.offset = to_field(begin_a);
            k2.length = span(pos_reg, begin_a, 1'b1);
            if (accepting(mode_a)) begin
                e2      = 1'b1;
                k2.kind = K_NUMBER;
            end else if ((mode_a != M_IDLE) && (mode_a != M_ERR)) begin
                e2      = 1'b1;
                k2.kind = K_ERROR;
            end
        end
    end

    // compaction of the three candidates into two slots
    always_comb begin
        push.v0 = step && (e0 || e1 || e2);
        push.v1 = step && ((e0 && (e1 || e2)) || (e1 && e2));
        push.t0 = e0 ? k0 : e1 ? k1 : k2;
        push.t1 = (e0 && e1) ? k1 : k2;
        push.t0.last = !push.v1;
        push.t1.last = 1'b1;
    end

    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        idx_next   = idx_reg;
        lkind_next = lkind_reg;
        if (step) begin
            if (end_of_text) begin
                mode_next  = M_IDLE;
                pos_next   = '0;
                begin_next = '0;
                idx_next   = 3'd0;
                lkind_next = 2'd0;
            end else begin
                mode_next  = mode_a;
                begin_next = begin_a;
                idx_next   = idx_a;
                lkind_next = lkind_a;
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + pos_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            idx_reg   <= 3'd0;
            lkind_reg <= 2'd0;
        end else begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            idx_reg   <= idx_next;
            lkind_reg <= lkind_next;
        end
    end

endmodule

/* hw/rtl/jbl_tokq.sv */
// ----------------------------------------------------------------------------
// jbl_tokq
// Token queue: takes up to two tokens per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module jbl_tokq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  jbl_pkg::push_t             push,
    output jbl_pkg::tokq_stat_t        stat,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output jbl_pkg::tok_t              head
);
    import jbl_pkg::*;

    tok_t                 mem_reg [TOKQ_DEPTH];
    logic [TOKQ_AW-1:0]   wr_reg, wr_next;
    logic [TOKQ_AW-1:0]   wr_inc;
    logic [TOKQ_AW-1:0]   rd_reg, rd_next;
    logic [TOKQ_AW:0]     count_reg, count_next;
    logic                 pop;

    assign m_tvalid   = (count_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign pop        = m_tvalid && m_tready;
    assign stat.count = count_reg;
    assign stat.room  = (count_reg <= (TOKQ_AW + 1)'(TOKQ_DEPTH - 2));
    assign wr_inc     = wr_reg + TOKQ_AW'(1);

    always_comb begin
        wr_next    = wr_reg + TOKQ_AW'(push.v0) + TOKQ_AW'(push.v1);
        rd_next    = rd_reg + TOKQ_AW'(pop);
        count_next = count_reg + (TOKQ_AW + 1)'(push.v0) + (TOKQ_AW + 1)'(push.v1)
                     - (TOKQ_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TOKQ_DEPTH; i++) begin
            if (push.v0 && (TOKQ_AW'(i) == wr_reg)) begin
                mem_reg[i] <= push.t0;
            end else if (push.v1 && (TOKQ_AW'(i) == wr_inc)) begin
                mem_reg[i] <= push.t1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/json_byte_lexer_unit.sv */
// ----------------------------------------------------------------------------
// json_byte_lexer_unit
// Streaming JSON lexer: text bytes in, tokens with offset and length out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tlast
//  s_      | in  | text_byte[7:0]                 | end_of_text
//  m_      | out | kind[3:0] offset[19:4] len[35:20] | last_of_run
//
//  One byte accepted per cycle while the token queue has room; a byte is held in the input
//  register until the lexer steps on it, and its tokens enter the queue the cycle after that step.
//  A byte may give two tokens; the four-entry token queue drains one per
//  transfer, and the input stalls while fewer than two slots are free.
//  aresetn is synchronous and clears the mode, position and queue pointers.
//  The end-of-text byte returns the lexer to offset zero for the next text.
// ----------------------------------------------------------------------------
module json_byte_lexer_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [jbl_pkg::S_TDATA_W-1:0]   s_tdata,   // text_byte[7:0]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [jbl_pkg::M_TDATA_W-1:0]   m_tdata,   // token_kind, token_offset, token_length
    output logic                            m_tlast
);
    import jbl_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        step;
    logic        s_xfer;
    push_t       push;
    tokq_stat_t  stat;
    tok_t        head;

    assign step     = in_valid_reg && stat.room;
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_tdata[7:0];
            in_end_reg  <= s_tlast;
        end
    end

    jbl_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .text_byte   (in_byte_reg),
        .end_of_text (in_end_reg),
        .push        (push)
    );

    jbl_tokq u_tokq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {4'b0000, head.length, head.offset, head.kind};
    assign m_tlast = head.last;

    `include "json_byte_lexer_unit_assert.svh"

    `JBL_ASSERT_NOW(a_push_compact, push.v1, push.v0 && push.t1.last && !push.t0.last,
        "second token pushed without first or run end misplaced")
    `JBL_ASSERT_NOW(a_push_only_on_step, push.v0, step,
        "token pushed without a lexer step")
    `JBL_ASSERT_NOW(a_queue_bound, 1'b1, stat.count <= (TOKQ_AW + 1)'(TOKQ_DEPTH),
        "token queue overfilled")
    `JBL_ASSERT_NEXT(a_held_byte, in_valid_reg && !step,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_end_reg),
        "held byte lost while lexer stalled")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// JSON byte lexer testbench
// Streams JSON texts byte by byte into json_byte_lexer_unit and checks every
// token transfer against a cycle-free model of the lexer's mode machine, or a
// token typed in its row. Directed bytes from a short table come first. Random
// texts follow: mostly well-formed token streams of random content, with some
// noise, in three phases of handshake pressure, each drained before the next.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jbl_pkg::*;

    localparam int unsigned POS_MAX     = (1 << 16) - 1;
    localparam int          STALL_LIMIT = 4000;
    localparam int          PHASE_BYTES = 600;

    typedef enum logic [3:0] {
        LX_IDLE, LX_STR, LX_ESC, LX_LIT, LX_MINUS, LX_ZERO, LX_INT,
        LX_DOT, LX_FRAC, LX_EXP, LX_EXPSIGN, LX_EXPDIG, LX_ERR
    } lex_mode_e;

    typedef struct {
        logic [7:0] ch;
        bit         eot;
        bit         typed;
        tok_t       tok;
    } row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    int send_idle_pct = 29;
    int recv_idle_pct = 65;
    int errors        = 0;
    int stall_cycles  = 0;

    // lexer model state
    lex_mode_e   lx_mode;
    int unsigned lx_pos;
    int unsigned lx_begin;
    int unsigned lit_idx;
    int unsigned lit_k;

    string      lit_words[3] = '{"true", "false", "null"};
    logic [3:0] lit_kinds[3] = '{K_TRUE, K_FALSE, K_NULL};

    tok_t       byte_tokens[$];
    tok_t       pending_tokens[$];
    logic [7:0] text_q[$];

    row_t dir_rows[27] = '{
        '{"{",      1'b0, 1'b1, '{K_LBRACE, 16'd0, 16'd1, 1'b1}},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_BSL,   1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{":",      1'b0, 1'b0, '0},
        '{"-",      1'b0, 1'b0, '0},
        '{"0",      1'b0, 1'b0, '0},
        '{"e",      1'b0, 1'b0, '0},
        '{"5",      1'b0, 1'b0, '0},
        '{",",      1'b0, 1'b0, '0},
        '{"[",      1'b0, 1'b0, '0},
        '{"n",      1'b0, 1'b0, '0},
        '{"u",      1'b0, 1'b0, '0},
        '{"l",      1'b0, 1'b0, '0},
        '{"l",      1'b0, 1'b0, '0},
        '{"t",      1'b0, 1'b0, '0},
        '{"r",      1'b0, 1'b0, '0},
        '{"u",      1'b0, 1'b0, '0},
        '{"e",      1'b0, 1'b0, '0},
        '{"]",      1'b0, 1'b0, '0},
        '{"}",      1'b0, 1'b0, '0},
        '{".",      1'b0, 1'b1, '{K_ERROR, 16'd22, 16'd1, 1'b1}},
        '{8'hFF,    1'b1, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h00,    1'b1, 1'b1, '{K_ERROR, 16'd0, 16'd2, 1'b1}},
        '{"7",      1'b1, 1'b1, '{K_NUMBER, 16'd0, 16'd1, 1'b1}}
    };

    json_byte_lexer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------------
    function automatic bit is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int punct_kind(input logic [7:0] c);
        case (c)
            "{":     return K_LBRACE;
            "[":     return K_LBRACK;
            "}":     return K_RBRACE;
            "]":     return K_RBRACK;
            ":":     return K_COLON;
            ",":     return K_COMMA;
            default: return -1;
        endcase
    endfunction

    function automatic bit is_escapable(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSL || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t" || c == "u";
    endfunction

    function automatic bit number_complete(input lex_mode_e m);
        return m == LX_ZERO || m == LX_INT || m == LX_FRAC || m == LX_EXPDIG;
    endfunction

    function automatic lex_mode_e number_next(input lex_mode_e m, input logic [7:0] c);
        bit d, e;
        d = is_digit(c);
        e = (c == "e") || (c == "E");
        case (m)
            LX_MINUS:   return (c == "0") ? LX_ZERO : d ? LX_INT : LX_ERR;
            LX_ZERO:    return (c == ".") ? LX_DOT : e ? LX_EXP : LX_ERR;
            LX_INT:     return d ? LX_INT : (c == ".") ? LX_DOT : e ? LX_EXP : LX_ERR;
            LX_DOT:     return d ? LX_FRAC : LX_ERR;
            LX_FRAC:    return d ? LX_FRAC : e ? LX_EXP : LX_ERR;
            LX_EXP:     return (c == "+" || c == "-") ? LX_EXPSIGN : d ? LX_EXPDIG : LX_ERR;
            LX_EXPSIGN: return d ? LX_EXPDIG : LX_ERR;
            LX_EXPDIG:  return d ? LX_EXPDIG : LX_ERR;
            default:    return LX_ERR;
        endcase
    endfunction

    function automatic void lex_reset();
        lx_mode  = LX_IDLE;
        lx_pos   = 0;
        lx_begin = 0;
        lit_idx  = 0;
        lit_k    = 0;
    endfunction

    function automatic void put_token(input logic [3:0] kind, input int unsigned off,
                                      input int unsigned len);
        tok_t t;
        if (byte_tokens.size() >= 2) return;
        if (len > POS_MAX) len = POS_MAX;
        t.kind   = kind;
        t.offset = off[15:0];
        t.length = len[15:0];
        t.last   = 1'b0;
        byte_tokens.insert(byte_tokens.size(), t);
    endfunction

    function automatic void fail_at(input int unsigned pos);
        put_token(K_ERROR, lx_begin, pos - lx_begin + 1);
        lx_mode = LX_ERR;
    endfunction

    function automatic void start_at(input logic [7:0] c, input int unsigned pos);
        int p;
        p = punct_kind(c);
        lx_begin = pos;
        if (is_space(c)) return;
        if (p >= 0) begin
            put_token(p[3:0], pos, 1);
        end else if (c == CH_QUOTE) begin
            lx_mode = LX_STR;
        end else if (c == "-") begin
            lx_mode = LX_MINUS;
        end else if (c == "0") begin
            lx_mode = LX_ZERO;
        end else if (is_digit(c)) begin
            lx_mode = LX_INT;
        end else if (c == "t" || c == "f" || c == "n") begin
            lit_k   = (c == "t") ? 0 : (c == "f") ? 1 : 2;
            lit_idx = 1;
            lx_mode = LX_LIT;
        end else begin
            fail_at(pos);
        end
    endfunction

    // tokens caused by one text byte land in byte_tokens
    function automatic void lex_byte(input logic [7:0] c, input bit eot);
        int unsigned pos;
        lex_mode_e   nx;
        byte_tokens.delete();
        pos = lx_pos;
        case (lx_mode)
            LX_IDLE: start_at(c, pos);
            LX_STR: begin
                if (c == CH_BSL) begin
                    lx_mode = LX_ESC;
                end else if (c == CH_QUOTE) begin
                    put_token(K_STRING, lx_begin, pos - lx_begin + 1);
                    lx_mode = LX_IDLE;
                end
            end
            LX_ESC: begin
                if (is_escapable(c)) lx_mode = LX_STR;
                else fail_at(pos);
            end
            LX_LIT: begin
                if (lit_idx < lit_words[lit_k].len() && c == lit_words[lit_k][lit_idx]) begin
                    lit_idx++;
                    if (lit_idx == lit_words[lit_k].len()) begin
                        put_token(lit_kinds[lit_k], lx_begin, pos - lx_begin + 1);
                        lx_mode = LX_IDLE;
                        lit_idx = 0;
                    end
                end else begin
                    fail_at(pos);
                end
            end
            LX_ERR: ;
            default: begin
                if (number_complete(lx_mode) && (is_space(c) || punct_kind(c) >= 0)) begin
                    put_token(K_NUMBER, lx_begin, pos - lx_begin);
                    lx_mode = LX_IDLE;
                    start_at(c, pos);
                end else begin
                    nx = number_next(lx_mode, c);
                    if (nx == LX_ERR) fail_at(pos);
                    else lx_mode = nx;
                end
            end
        endcase

        if (eot) begin
            if (number_complete(lx_mode))
                put_token(K_NUMBER, lx_begin, pos - lx_begin + 1);
            else if (lx_mode != LX_IDLE && lx_mode != LX_ERR)
                put_token(K_ERROR, lx_begin, pos - lx_begin + 1);
            lex_reset();
        end else if (lx_pos < POS_MAX) begin
            lx_pos++;
        end

        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic logic [7:0] pick_ws();
        logic [7:0] b;
        b = 8'($urandom_range(5, 0));
        return (b == 5) ? 8'h20 : 8'h09 + b;
    endfunction

    function automatic logic [7:0] pick_punct();
        string p;
        p = "{[}]:,";
        return p[$urandom_range(5, 0)];
    endfunction

    function automatic logic [7:0] pick_str_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 0)); while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    function automatic void add_number();
        if ($urandom_range(99, 0) < 30) add_byte("-");
        if ($urandom_range(99, 0) < 25) begin
            add_byte("0");
        end else begin
            add_byte(8'("1" + $urandom_range(8, 0)));
            repeat ($urandom_range(4, 0)) add_byte(8'("0" + $urandom_range(9, 0)));
        end
        if ($urandom_range(99, 0) < 40) begin
            add_byte(".");
            repeat ($urandom_range(3, 1)) add_byte(8'("0" + $urandom_range(9, 0)));
        end
        if ($urandom_range(99, 0) < 35) begin
            add_byte($urandom_range(1, 0) ? "e" : "E");
            if ($urandom_range(1, 0)) add_byte($urandom_range(1, 0) ? "+" : "-");
            repeat ($urandom_range(2, 1)) add_byte(8'("0" + $urandom_range(9, 0)));
        end
    endfunction

    function automatic void add_string();
        string esc;
        esc = "\"\\/bfnrtu";
        add_byte(CH_QUOTE);
        repeat ($urandom_range(8, 0)) begin
            if ($urandom_range(99, 0) < 15) begin
                add_byte(CH_BSL);
                add_byte(esc[$urandom_range(8, 0)]);
            end else begin
                add_byte(pick_str_byte());
            end
        end
        add_byte(CH_QUOTE);
    endfunction

    function automatic void add_literal(input int unsigned k);
        for (int i = 0; i < lit_words[k].len(); i++) add_byte(lit_words[k][i]);
    endfunction

    function automatic void add_noise();
        case ($urandom_range(3, 0))
            0: add_byte(8'($urandom_range(255, 0)));
            1: begin
                add_byte("t");
                add_byte("r");
                add_byte("x");
            end
            2: begin
                add_byte(CH_QUOTE);
                add_byte(CH_BSL);
                add_byte("q");
            end
            default: begin
                add_byte("1");
                add_byte(".");
                add_byte(",");
            end
        endcase
    endfunction

    function automatic void build_text();
        int r;
        text_q.delete();
        repeat ($urandom_range(16, 1)) begin
            if ($urandom_range(99, 0) < 30) add_byte(pick_ws());
            r = $urandom_range(99, 0);
            if (r < 25) begin
                add_byte(pick_punct());
            end else if (r < 47) begin
                add_number();
                add_byte($urandom_range(1, 0) ? pick_ws() : pick_punct());
            end else if (r < 70) begin
                add_string();
            end else if (r < 88) begin
                add_literal($urandom_range(2, 0));
            end else if (r < 97) begin
                add_byte(pick_ws());
            end else begin
                add_noise();
            end
        end
        // sometimes leave a token open at end of text
        r = $urandom_range(99, 0);
        if (r < 10) begin
            add_number();
        end else if (r < 16) begin
            add_byte(CH_QUOTE);
            add_byte("a");
        end else if (r < 20) begin
            add_byte("f");
            add_byte("a");
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] ch, input bit eot, input bit typed,
                             input tok_t typed_tok);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lex_byte(ch, eot);
        if (typed) pending_tokens.insert(pending_tokens.size(), typed_tok);
        else foreach (byte_tokens[i]) pending_tokens.insert(pending_tokens.size(), byte_tokens[i]);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
    endtask

    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tokens.size() != 0);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    initial begin
        int sent;
        int send_pcts[3];
        int recv_pcts[3];
        send_pcts = '{29, 65, 0};
        recv_pcts = '{65, 29, 0};
        lex_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].tok);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pcts[ph];
            recv_idle_pct = recv_pcts[ph];
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_text();
                send_text();
                sent += text_q.size();
            end
            drain_tokens();
        end

        drain_tokens();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : check_tokens
        tok_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token transfer, expected none, got tdata %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tdata[3:0]));
                check_field("offset", 32'(want.offset), 32'(m_tdata[19:4]));
                check_field("length", 32'(want.length), 32'(m_tdata[35:20]));
                check_field("padding", 0, 32'(m_tdata[39:36]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
